>>> hw/rtl/hsv_percent_to_rgb8_assert.svh
// Assertion macros used by the RTL of the HSV to RGB converter.
// Define ASSERT_OFF to compile them out.
`ifndef HSV_PERCENT_TO_RGB8_ASSERT_SVH
`define HSV_PERCENT_TO_RGB8_ASSERT_SVH

`ifndef ASSERT_OFF

// cons must hold in every cycle in which ante holds
`define HSV_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// cond must never hold out of reset
`define HSV_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
		else $error(msg);

`else

`define HSV_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons, msg)
`define HSV_ASSERT_NEVER(lbl, clk_i, rstn_i, cond, msg)

`endif

`endif

>>> hw/rtl/hsvrgb_pkg.sv
package hsvrgb_pkg;

	localparam int PCT_W  = 7;
	localparam int CH_W   = 8;
	localparam int K_W    = 6;   // ramp numerator 0..50
	localparam int VS_W   = 14;  // v*s, v*100 up to 10000
	localparam int N_W    = 19;  // numerator over 500000, up to 500000
	localparam int X_W    = 25;  // n*51
	localparam int Y_W    = 20;  // n*51 / 32
	localparam int Q_W    = 9;
	localparam int RECIP_SHIFT = 32;
	localparam int P_W    = 41;  // y * reciprocal

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [K_W-1:0]   K_FULL  = 6'd50;
	localparam logic [VS_W-1:0]  PCT_SCALE = 14'd100;
	localparam logic [N_W-1:0]   OFS_MUL = 19'd50;
	localparam logic [X_W-1:0]   FS_MUL  = 25'd51;      // 255/500000 = 51/100000
	localparam logic [20:0]      RECIP   = 21'd1374389;  // floor(2^32 / 3125)
	localparam logic [Y_W-1:0]   DIV_LO  = 20'd3125;     // 100000 / 32
	localparam logic [Q_W-1:0]   CH_MAX  = 9'd255;

	// 60 degree hue sectors
	typedef enum logic [2:0] {
		SEC_RY,  // red to yellow
		SEC_YG,  // yellow to green
		SEC_GC,  // green to cyan
		SEC_CB,  // cyan to blue
		SEC_BM,  // blue to magenta
		SEC_MR   // magenta to red
	} sector_t;

	typedef struct packed {
		sector_t        sec;
		logic [K_W-1:0] k;
	} hue_t;

	// clamp a 7-bit percentage to 100
	function automatic logic [PCT_W-1:0] limit_pct(input logic [PCT_W-1:0] x);
		return (x > PCT_MAX) ? PCT_MAX : x;
	endfunction

	// sector and ramp numerator for hue 0..100 (3*h over 50 is H/60)
	function automatic hue_t hue_decode(input logic [PCT_W-1:0] h);
		logic [8:0] h9;
		logic [8:0] h3;
		logic [8:0] t;
		hue_t       r;
		h9 = {2'b00, h};
		h3 = h9 + {h9[7:0], 1'b0};
		if (h3 < 9'd50)       r.sec = SEC_RY;
		else if (h3 < 9'd100) r.sec = SEC_YG;
		else if (h3 < 9'd150) r.sec = SEC_GC;
		else if (h3 < 9'd200) r.sec = SEC_CB;
		else if (h3 < 9'd250) r.sec = SEC_BM;
		else                  r.sec = SEC_MR;
		if (h3 < 9'd100)      t = h3;
		else if (h3 < 9'd200) t = h3 - 9'd100;
		else if (h3 < 9'd300) t = h3 - 9'd200;
		else                  t = h3 - 9'd300;
		r.k = (t >= 9'd50) ? K_W'(9'd100 - t) : K_W'(t);
		return r;
	endfunction

	// ramp numerator of one channel (0 red, 1 green, 2 blue)
	function automatic logic [K_W-1:0] chan_k(input sector_t sec, input logic [K_W-1:0] k,
			input logic [1:0] ch);
		logic [K_W-1:0] kr, kg, kb;
		unique case (sec)
			SEC_RY:  begin kr = K_FULL; kg = k;      kb = '0;     end
			SEC_YG:  begin kr = k;      kg = K_FULL; kb = '0;     end
			SEC_GC:  begin kr = '0;     kg = K_FULL; kb = k;      end
			SEC_CB:  begin kr = '0;     kg = k;      kb = K_FULL; end
			SEC_BM:  begin kr = k;      kg = '0;     kb = K_FULL; end
			default: begin kr = K_FULL; kg = '0;     kb = k;      end
		endcase
		case (ch)
			2'd0:    return kr;
			2'd1:    return kg;
			default: return kb;
		endcase
	endfunction

endpackage

>>> hw/rtl/hsv_percent_to_rgb8.sv
// HSV to 8-bit RGB converter. Hue, saturation and value arrive as percentages
// (0..100, larger codes count as 100); hue covers the full circle. One item is
// taken on every clock in which start is high: busy is tied low, since the
// six-stage pipeline never stalls. The converted color appears on red_out,
// green_out and blue_out for exactly one cycle with strobe high, in the cycle
// after the fifth clock edge that follows the item being taken, so it must be
// taken at the sixth edge; items come out in order and the receiver cannot
// hold them off. Each channel is floor(255*(channel+m)) computed exactly in
// integer math.
`include "hsv_percent_to_rgb8_assert.svh"

module hsv_percent_to_rgb8 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [hsvrgb_pkg::PCT_W-1:0] hue_pct,
	input  logic [hsvrgb_pkg::PCT_W-1:0] sat_pct,
	input  logic [hsvrgb_pkg::PCT_W-1:0] val_pct,
	output logic                         strobe,
	output logic [hsvrgb_pkg::CH_W-1:0]  red_out,
	output logic [hsvrgb_pkg::CH_W-1:0]  green_out,
	output logic [hsvrgb_pkg::CH_W-1:0]  blue_out
);
	import hsvrgb_pkg::*;

	// valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1: clamp, hue decode
	hue_t             hue_s1;
	logic [PCT_W-1:0] s_s1, val_s1;
	// stage 2: v*s, v*100
	hue_t             hue_s2;
	logic [VS_W-1:0]  vs_s2, v100_s2;
	// stage 3: numerators, per channel
	logic [N_W-1:0]   n_s3 [3];
	// stage 4: scaled by 51/32
	logic [Y_W-1:0]   y_s4 [3];
	// stage 5: quotient estimate
	logic [Y_W-1:0]   y_s5 [3];
	logic [Q_W-1:0]   q0_s5 [3];
	// stage 6: results
	logic [CH_W-1:0]  ch_s6 [3];

	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// stages 1 and 2
	always_ff @(posedge clk) begin
		hue_s1 <= hue_decode(limit_pct(hue_pct));
		s_s1   <= limit_pct(sat_pct);
		val_s1 <= limit_pct(val_pct);

		hue_s2  <= hue_s1;
		vs_s2   <= VS_W'(val_s1) * VS_W'(s_s1);
		v100_s2 <= VS_W'(val_s1) * PCT_SCALE;
	end

	// stages 3 to 6, one lane per channel
	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [K_W-1:0]  kc;
		logic [X_W-1:0]  x;
		logic [P_W-1:0]  p;
		logic [Y_W-1:0]  rem;
		logic [Q_W-1:0]  q;

		assign kc  = chan_k(hue_s2.sec, hue_s2.k, 2'(c));
		assign x   = X_W'(n_s3[c]) * FS_MUL;
		assign p   = P_W'(y_s4[c]) * P_W'(RECIP);
		// estimate is low by at most one
		assign rem = y_s5[c] - Y_W'(q0_s5[c]) * DIV_LO;

		always_comb begin
			q = (rem >= DIV_LO) ? q0_s5[c] + Q_W'(1) : q0_s5[c];
			if (q > CH_MAX) q = CH_MAX;
		end

		always_ff @(posedge clk) begin
			n_s3[c]  <= N_W'(vs_s2) * N_W'(kc) + OFS_MUL * N_W'(v100_s2 - vs_s2);
			y_s4[c]  <= x[X_W-1:5];
			y_s5[c]  <= y_s4[c];
			q0_s5[c] <= p[P_W-1:RECIP_SHIFT];
			ch_s6[c] <= q[CH_W-1:0];
		end
	end

	assign strobe    = v_s6;
	assign red_out   = ch_s6[0];
	assign green_out = ch_s6[1];
	assign blue_out  = ch_s6[2];

	// checks
	`HSV_ASSERT_IMPLY(a_strobe_follows_item, clk, arst_n, strobe,
		$past(start, 6), "result without an item six cycles earlier")
	`HSV_ASSERT_IMPLY(a_gray_when_unsaturated, clk, arst_n, strobe && $past(sat_pct == 7'd0, 6),
		red_out == green_out && green_out == blue_out, "zero saturation gave a tint")
	`HSV_ASSERT_IMPLY(a_black_when_dark, clk, arst_n, strobe && $past(val_pct == 7'd0, 6),
		red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0, "zero value not black")
	`HSV_ASSERT_NEVER(a_never_busy, clk, arst_n, busy, "pipeline reported a stall")

endmodule

>>> tb/tb.sv
module tb;
	import hsvrgb_pkg::*;

	// scaling constants of the exact integer conversion
	localparam int unsigned PCT_FULL   = 100;
	localparam int unsigned RAMP_FULL  = 50;
	localparam int unsigned SECTOR_LEN = 50;
	localparam longint unsigned NUM_DEN = 500000;
	localparam longint unsigned CH_FULL = 255;
	localparam int IDLE_PCT     = 27;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [PCT_W-1:0] hue_pct;
	logic [PCT_W-1:0] sat_pct;
	logic [PCT_W-1:0] val_pct;
	logic strobe;
	logic [CH_W-1:0] red_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] blue_out;

	rgb_t pending_colors[$];
	int   mismatch_count = 0;
	bit   sender_idles = 1'b1;

	hsv_percent_to_rgb8 uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue_pct   (hue_pct),
		.sat_pct   (sat_pct),
		.val_pct   (val_pct),
		.strobe    (strobe),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// percentages above 100 count as 100
	function automatic int unsigned clamp_pct(input logic [PCT_W-1:0] x);
		return (x > PCT_FULL) ? PCT_FULL : int'(x);
	endfunction

	// floor(255 * n / 500000), n = v*s*k + 50*(100*v - v*s)
	function automatic logic [CH_W-1:0] scale_channel(input int unsigned vs,
			input int unsigned v, input int unsigned k);
		longint unsigned n;
		longint unsigned c;
		n = longint'(vs) * k + 64'd50 * (longint'(PCT_FULL) * v - vs);
		c = (CH_FULL * n) / NUM_DEN;
		if (c > CH_FULL)
			c = CH_FULL;
		return c[CH_W-1:0];
	endfunction

	// exact HSV percentages to 8-bit RGB
	function automatic rgb_t hsv_to_rgb(input logic [PCT_W-1:0] h_in,
			input logic [PCT_W-1:0] s_in, input logic [PCT_W-1:0] v_in);
		int unsigned h, s, v, h3, sec_idx, t, k, vs, kr, kg, kb;
		sector_t sec;
		rgb_t c;
		h = clamp_pct(h_in);
		s = clamp_pct(s_in);
		v = clamp_pct(v_in);
		h3 = 3 * h;
		sec_idx = h3 / SECTOR_LEN;
		if (sec_idx > 5)
			sec_idx = 5;
		sec = sector_t'(3'(sec_idx));
		t = h3 % PCT_FULL;
		k = (t >= RAMP_FULL) ? (PCT_FULL - t) : t;
		vs = v * s;
		case (sec)
			SEC_RY: begin kr = RAMP_FULL; kg = k;         kb = 0;         end
			SEC_YG: begin kr = k;         kg = RAMP_FULL; kb = 0;         end
			SEC_GC: begin kr = 0;         kg = RAMP_FULL; kb = k;         end
			SEC_CB: begin kr = 0;         kg = k;         kb = RAMP_FULL; end
			SEC_BM: begin kr = k;         kg = 0;         kb = RAMP_FULL; end
			default: begin kr = RAMP_FULL; kg = 0;        kb = k;         end
		endcase
		c.red   = scale_channel(vs, v, kr);
		c.green = scale_channel(vs, v, kg);
		c.blue  = scale_channel(vs, v, kb);
		return c;
	endfunction

	// present one item, hold it until taken, then queue its color
	task automatic send_color(input logic [PCT_W-1:0] h, input logic [PCT_W-1:0] s,
			input logic [PCT_W-1:0] v);
		if (sender_idles) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start   <= 1'b1;
		hue_pct <= h;
		sat_pct <= s;
		val_pct <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_colors.push_back(hsv_to_rgb(h, s, v));
	endtask

	// hold off until every queued color has come out
	task automatic wait_pipeline_empty();
		start <= 1'b0;
		@(posedge clk);
		while (pending_colors.size() != 0)
			@(posedge clk);
	endtask

	// compare each result with the oldest queued color
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && strobe) begin
			if (pending_colors.size() == 0) begin
				$error("unexpected result: red %0d green %0d blue %0d",
					red_out, green_out, blue_out);
				mismatch_count++;
			end else begin
				want = pending_colors.pop_front();
				if (red_out !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, red_out);
					mismatch_count++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, green_out);
					mismatch_count++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, blue_out);
					mismatch_count++;
				end
			end
		end
	end

	// field extremes, every hue sector and its edges, zero saturation, clamping
	task automatic test_directed_corners();
		send_color(7'd0, 7'd0, 7'd0);
		send_color(7'd100, 7'd100, 7'd100);
		send_color(7'd127, 7'd127, 7'd127);
		send_color(7'd0, 7'd0, 7'd100);
		send_color(7'd50, 7'd0, 7'd73);
		send_color(7'd100, 7'd60, 7'd80);
		send_color(7'd8, 7'd100, 7'd100);
		send_color(7'd25, 7'd100, 7'd100);
		send_color(7'd42, 7'd100, 7'd100);
		send_color(7'd58, 7'd100, 7'd100);
		send_color(7'd75, 7'd100, 7'd100);
		send_color(7'd92, 7'd100, 7'd100);
		send_color(7'd16, 7'd90, 7'd70);
		send_color(7'd17, 7'd90, 7'd70);
		send_color(7'd33, 7'd90, 7'd70);
		send_color(7'd34, 7'd90, 7'd70);
		send_color(7'd66, 7'd90, 7'd70);
		send_color(7'd67, 7'd90, 7'd70);
		send_color(7'd83, 7'd90, 7'd70);
		send_color(7'd84, 7'd90, 7'd70);
		send_color(7'd101, 7'd101, 7'd101);
		send_color(7'd127, 7'd50, 7'd50);
		send_color(7'd50, 7'd127, 7'd50);
		send_color(7'd50, 7'd50, 7'd127);
		send_color(7'd1, 7'd1, 7'd1);
	endtask

	// random colors, mostly in range, some with codes above 100
	task automatic test_random_colors(input int count);
		logic [PCT_W-1:0] h, s, v;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75) begin
				h = PCT_W'($urandom_range(PCT_FULL));
				s = PCT_W'($urandom_range(PCT_FULL));
				v = PCT_W'($urandom_range(PCT_FULL));
			end else begin
				h = PCT_W'($urandom_range(127));
				s = PCT_W'($urandom_range(127));
				v = PCT_W'($urandom_range(127));
			end
			send_color(h, s, v);
			if (i == count / 2)
				wait_pipeline_empty();
		end
	endtask

	// one item per clock with no idle gaps, but for one drain of the pipeline halfway
	task automatic test_streaming_colors(input int count);
		sender_idles = 1'b0;
		test_random_colors(count);
		sender_idles = 1'b1;
	endtask

	initial begin
		arst_n  <= 1'b0;
		start   <= 1'b0;
		hue_pct <= '0;
		sat_pct <= '0;
		val_pct <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_random_colors(400);
		test_streaming_colors(200);
		test_random_colors(300);

		wait_pipeline_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_colors.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#200000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
